>>> rtl/bpa_pkg.sv
// Shared types and constants of the bitmap page allocator.
`timescale 1ns / 1ps
`default_nettype none
package bpa_pkg;

  // Pool geometry
  localparam int MAX_PAGES  = 8192;
  localparam int PAGE_SHIFT = 12;
  localparam int WORD_BITS  = 32;
  localparam int WORD_CNT   = MAX_PAGES / WORD_BITS;
  localparam int WORD_AW    = $clog2(WORD_CNT);
  localparam int BIT_AW     = $clog2(WORD_BITS);
  localparam int PIDX_W     = WORD_AW + BIT_AW;
  localparam int CNT_W      = PIDX_W + 1;
  localparam int ADDR_W     = 32;

  // Commands carried in in_tuser
  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_FREE  = 2'd2;

  // Result status carried in out_tuser
  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_NOMEM   = 2'd1;
  localparam logic [1:0] STAT_IGNORED = 2'd2;

  // Configuration register indexes
  localparam logic CFG_MEM_BYTES = 1'b0;
  localparam logic CFG_RESERVED  = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_ALLOC,
    S_FREE,
    S_DONE
  } state_t;

  // First-free search result of one bitmap word
  typedef struct packed {
    logic              found;
    logic [BIT_AW-1:0] bit_idx;
  } scan_res_t;

endpackage
`default_nettype wire

>>> rtl/bpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> rtl/bpa_word_scan.sv
// Shared word unit: page range mask and lowest free page of one bitmap word.
`timescale 1ns / 1ps
`default_nettype none
module bpa_word_scan
  import bpa_pkg::*;
(
  input  wire logic [WORD_BITS-1:0] word_data,
  input  wire logic [WORD_AW-1:0]   word_idx,
  input  wire logic [CNT_W-1:0]     lo,
  input  wire logic [CNT_W-1:0]     hi,
  output logic      [WORD_BITS-1:0] range_mask,
  output scan_res_t                 res
);

  logic [WORD_BITS-1:0] cand;

  // Mark pages with lo <= page < hi
  always_comb begin
    logic [CNT_W-1:0] page;
    for (int j = 0; j < WORD_BITS; j++) begin
      page          = {1'b0, word_idx, BIT_AW'(j)};
      range_mask[j] = (page >= lo) && (page < hi);
    end
  end

  assign cand = ~word_data & range_mask;

  // Pick the lowest free page in range
  always_comb begin
    res.found   = |cand;
    res.bit_idx = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (cand[j]) begin
        res.bit_idx = BIT_AW'(j);
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/bitmap_page_allocator_unit.sv
// Top level of the first-fit bitmap page allocator.
// One command is in flight at a time; in_tready is high only while idle, and the
// result sits in an output register so the next command can enter before it is
// taken. The bitmap lives in a 256 x 32 RAM walked one word per cycle by a shared
// word unit. Init writes all 256 words. Alloc reads one word per cycle up to the
// first word with a free page or the end of the pool. Free reads a single word and
// rewrites it only when the page is released. A command with code 3 is reported as
// ignored. A finished command waits while the output register still holds a result
// that has not been taken. Configuration writes are always taken.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_page_allocator_unit
  import bpa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Command stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] page_address
  input  wire logic [1:0]  in_tuser,   // [1:0] cmd
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [47:0] out_tdata,  // [31:0] alloc_address, [45:32] free_pages, zero fill
  output logic      [1:0]  out_tuser,  // [1:0] status
  // Configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  state_t               state_r, state_nxt;
  logic [WORD_AW-1:0]   scan_r, scan_nxt;
  logic [CNT_W-1:0]     limit_r, limit_nxt;
  logic [CNT_W-1:0]     free_total_r, free_total_nxt;
  logic [31:0]          mem_bytes_r;
  logic [CNT_W-1:0]     reserved_r;
  logic [PIDX_W-1:0]    free_idx_r, free_idx_nxt;
  logic                 free_ok_r, free_ok_nxt;
  logic [ADDR_W-1:0]    res_addr_r, res_addr_nxt;
  logic [1:0]           res_status_r, res_status_nxt;
  logic                 out_valid_r;
  logic [ADDR_W-1:0]    out_addr_r;
  logic [1:0]           out_status_r;
  logic [CNT_W-1:0]     out_free_r;
  logic                 load_out;

  logic                 wr_en;
  logic [WORD_AW-1:0]   wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [WORD_AW-1:0]   rd_addr;
  logic [WORD_BITS-1:0] rd_data;

  logic [CNT_W-1:0]     scan_lo;
  logic [WORD_BITS-1:0] range_mask;
  scan_res_t            scan_res;

  logic [CNT_W-1:0]     init_pages;
  logic [CNT_W-1:0]     next_base;
  logic                 in_fire;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Pages in the pool, saturated at the bitmap size
  assign init_pages = (|mem_bytes_r[31:PAGE_SHIFT+PIDX_W]) ? CNT_W'(MAX_PAGES)
                    : {1'b0, mem_bytes_r[PAGE_SHIFT+PIDX_W-1:PAGE_SHIFT]};

  // First page of the word after the one under scan
  assign next_base = {(scan_r == '1) ? 1'b1 : 1'b0,
                      scan_r + WORD_AW'(1), BIT_AW'(0)};

  assign scan_lo = (state_r == S_INIT) ? reserved_r : '0;

  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_CNT)
  ) u_bitmap (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bpa_word_scan u_scan (
    .word_data  (rd_data),
    .word_idx   (scan_r),
    .lo         (scan_lo),
    .hi         (limit_r),
    .range_mask (range_mask),
    .res        (scan_res)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_bytes_r <= 32'd33554432;
      reserved_r  <= CNT_W'(1024);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MEM_BYTES: mem_bytes_r <= cfg_data;
        CFG_RESERVED:  reserved_r  <= cfg_data[CNT_W-1:0];
        default:       ;
      endcase
    end
  end

  // Sequencer state and pool bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      limit_r      <= '0;
      free_total_r <= '0;
    end else begin
      state_r      <= state_nxt;
      limit_r      <= limit_nxt;
      free_total_r <= free_total_nxt;
    end
  end

  // Command working registers
  always_ff @(posedge clk) begin
    scan_r       <= scan_nxt;
    free_idx_r   <= free_idx_nxt;
    free_ok_r    <= free_ok_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
  end

  // Next state, RAM access and result
  always_comb begin
    state_nxt      = state_r;
    scan_nxt       = scan_r;
    limit_nxt      = limit_r;
    free_total_nxt = free_total_r;
    free_idx_nxt   = free_idx_r;
    free_ok_nxt    = free_ok_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    wr_en          = 1'b0;
    wr_addr        = scan_r;
    wr_data        = ~range_mask;
    rd_addr        = '0;
    load_out       = 1'b0;

    case (state_r)
      S_IDLE: begin
        res_addr_nxt   = '0;
        res_status_nxt = STAT_DONE;
        scan_nxt       = '0;
        free_idx_nxt   = in_tdata[PAGE_SHIFT+PIDX_W-1:PAGE_SHIFT];
        free_ok_nxt    = ~(|in_tdata[31:PAGE_SHIFT+PIDX_W]) &&
                         ({1'b0, in_tdata[PAGE_SHIFT+PIDX_W-1:PAGE_SHIFT]} < limit_r);
        rd_addr        = in_tdata[PAGE_SHIFT+PIDX_W-1:PAGE_SHIFT+BIT_AW];
        if (in_fire) begin
          case (in_tuser)
            CMD_INIT: begin
              limit_nxt      = init_pages;
              free_total_nxt = (init_pages > reserved_r) ? init_pages - reserved_r : '0;
              state_nxt      = S_INIT;
            end
            CMD_ALLOC: begin
              rd_addr   = '0;
              state_nxt = S_ALLOC;
            end
            CMD_FREE: begin
              state_nxt = S_FREE;
            end
            default: begin
              res_status_nxt = STAT_IGNORED;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end

      // Write one word per cycle: free only between reserved and limit
      S_INIT: begin
        wr_en    = 1'b1;
        scan_nxt = scan_r + WORD_AW'(1);
        if (scan_r == '1) begin
          state_nxt = S_DONE;
        end
      end

      // Check the word read last cycle, fetch the next one
      S_ALLOC: begin
        rd_addr = scan_r + WORD_AW'(1);
        if (scan_res.found) begin
          wr_en          = 1'b1;
          wr_data        = rd_data | (WORD_BITS'(1) << scan_res.bit_idx);
          if (free_total_r != '0) begin
            free_total_nxt = free_total_r - CNT_W'(1);
          end
          res_addr_nxt   = ADDR_W'({scan_r, scan_res.bit_idx, PAGE_SHIFT'(0)});
          state_nxt      = S_DONE;
        end else if (next_base >= limit_r) begin
          res_status_nxt = STAT_NOMEM;
          state_nxt      = S_DONE;
        end else begin
          scan_nxt = scan_r + WORD_AW'(1);
        end
      end

      // Release the page if it is in the pool and in use
      S_FREE: begin
        wr_addr   = free_idx_r[PIDX_W-1:BIT_AW];
        wr_data   = rd_data & ~(WORD_BITS'(1) << free_idx_r[BIT_AW-1:0]);
        state_nxt = S_DONE;
        if (free_ok_r && rd_data[free_idx_r[BIT_AW-1:0]]) begin
          wr_en          = 1'b1;
          free_total_nxt = free_total_r + CNT_W'(1);
        end else begin
          res_status_nxt = STAT_IGNORED;
        end
      end

      // Hand the result to the output register
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_addr_r   <= res_addr_r;
      out_status_r <= res_status_r;
      out_free_r   <= free_total_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_free_r, out_addr_r};
  assign out_tuser  = out_status_r;

endmodule
`default_nettype wire

>>> tb/tb_bitmap_page_allocator_unit.sv
// Self-checking testbench for the bitmap page allocator: directed cases, back-pressure and random traffic.
`timescale 1ns / 1ps
module tb_bitmap_page_allocator_unit;
  import bpa_pkg::*;

  // Command code with no meaning to the block
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  // One expected result transaction
  typedef struct packed {
    logic [ADDR_W-1:0] alloc_addr;
    logic [1:0]        status;
    logic [CNT_W-1:0]  free_pages;
  } page_reply_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] page_address
  logic [1:0]  in_tuser;   // [1:0] cmd
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [31:0] alloc_address, [45:32] free_pages, zero fill
  logic [1:0]  out_tuser;  // [1:0] status
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  // Shadow of the allocator
  logic [MAX_PAGES-1:0] page_used;
  int unsigned          pool_pages;
  int unsigned          free_count;
  logic [31:0]          shadow_mem_bytes;
  logic [CNT_W-1:0]     shadow_reserved;

  page_reply_t page_replies_due[$];
  int          fault_count;
  int          sink_hold_cycles;
  logic        quiet_mode;

  bitmap_page_allocator_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // Apply one command to the shadow bitmap and return the result it must produce
  function automatic page_reply_t predict_page_command(input logic [1:0] cmd,
                                                       input logic [31:0] addr);
    page_reply_t reply;
    int unsigned p;
    int unsigned idx;
    logic        found;
    reply.alloc_addr = '0;
    reply.status     = STAT_DONE;
    found            = 1'b0;
    case (cmd)
      CMD_INIT: begin
        pool_pages = shadow_mem_bytes >> PAGE_SHIFT;
        if (pool_pages > MAX_PAGES) pool_pages = MAX_PAGES;
        page_used  = '1;
        free_count = 0;
        for (p = 32'(shadow_reserved); p < pool_pages; p++) begin
          page_used[p] = 1'b0;
          free_count++;
        end
      end
      CMD_ALLOC: begin
        reply.status = STAT_NOMEM;
        for (p = 0; p < pool_pages && !found; p++) begin
          if (!page_used[p]) begin
            found        = 1'b1;
            page_used[p] = 1'b1;
            if (free_count > 0) free_count--;
            reply.alloc_addr = p << PAGE_SHIFT;
            reply.status     = STAT_DONE;
          end
        end
      end
      CMD_FREE: begin
        idx = addr >> PAGE_SHIFT;
        if (idx < pool_pages && page_used[idx]) begin
          page_used[idx] = 1'b0;
          free_count++;
        end else begin
          reply.status = STAT_IGNORED;
        end
      end
      default: begin
        reply.status = STAT_IGNORED;
      end
    endcase
    reply.free_pages = free_count[CNT_W-1:0];
    return reply;
  endfunction

  // Find some used page of the pool, starting the search at a random page
  function automatic logic pick_used_page(output int unsigned idx);
    int unsigned start;
    int unsigned k;
    logic        hit;
    hit = 1'b0;
    idx = 0;
    if (pool_pages == 0) return 1'b0;
    start = $urandom_range(0, pool_pages - 1);
    for (k = 0; k < pool_pages && !hit; k++) begin
      idx = (start + k) % pool_pages;
      hit = page_used[idx];
    end
    return hit;
  endfunction

  task automatic flag_fault(input string what, input logic [31:0] want,
                            input logic [31:0] got);
    fault_count++;
    if (fault_count <= 10)
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  // Offer one command; called at a rising edge, returns at the accepting edge
  task automatic issue_command(input logic [1:0] cmd, input logic [31:0] addr);
    int gap;
    gap = quiet_mode ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= addr;
    do @(posedge clk); while (!in_tready);
    page_replies_due.push_back(predict_page_command(cmd, addr));
  endtask

  // Write a register once the block has delivered every pending result
  task automatic write_register(input logic idx, input logic [31:0] value);
    in_tvalid <= 1'b0;
    while (page_replies_due.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_MEM_BYTES) shadow_mem_bytes = value;
    else shadow_reserved = value[CNT_W-1:0];
  endtask

  // Commands before any init, then an init with the reset register values
  task automatic test_before_init();
    issue_command(CMD_ALLOC, 32'h0);
    issue_command(CMD_FREE, 32'h0000_0000);
    issue_command(CMD_UNKNOWN, 32'hFFFF_FFFF);
    issue_command(CMD_INIT, 32'h0);
    issue_command(CMD_ALLOC, 32'h0);
  endtask

  // Exhaust a tiny pool, then free valid, already free and out-of-range pages
  task automatic test_small_pool();
    write_register(CFG_MEM_BYTES, (32'd8 << PAGE_SHIFT) | 32'h123);
    write_register(CFG_RESERVED, 32'd2);
    issue_command(CMD_INIT, 32'hFFFF_FFFF);
    repeat (7) issue_command(CMD_ALLOC, 32'h0);
    issue_command(CMD_FREE, (32'd5 << PAGE_SHIFT) | 32'hABC);
    issue_command(CMD_FREE, 32'd5 << PAGE_SHIFT);
    issue_command(CMD_FREE, 32'hFFFF_FFFF);
    issue_command(CMD_ALLOC, 32'h0);
  endtask

  // With nothing reserved the first grant is page zero at address zero
  task automatic test_first_page();
    write_register(CFG_RESERVED, 32'd0);
    write_register(CFG_MEM_BYTES, (32'd4 << PAGE_SHIFT) | 32'd100);
    issue_command(CMD_INIT, 32'h0);
    issue_command(CMD_ALLOC, 32'h0);
    issue_command(CMD_FREE, 32'h0000_0FFF);
  endtask

  // Empty pool, then a saturated pool with every page reserved
  task automatic test_pool_extremes();
    write_register(CFG_MEM_BYTES, 32'h0);
    issue_command(CMD_INIT, 32'h0);
    issue_command(CMD_ALLOC, 32'h0);
    write_register(CFG_MEM_BYTES, 32'hFFFF_FFFF);
    write_register(CFG_RESERVED, 32'd8192);
    issue_command(CMD_INIT, 32'h0);
    issue_command(CMD_ALLOC, 32'h0);
    issue_command(CMD_FREE, (32'd8191 << PAGE_SHIFT) | 32'hFFF);
    issue_command(CMD_ALLOC, 32'h0);
  endtask

  // Hold off the result side so the block fills up and stalls its input
  task automatic test_output_backpressure();
    write_register(CFG_MEM_BYTES, 32'd64 << PAGE_SHIFT);
    write_register(CFG_RESERVED, 32'd0);
    issue_command(CMD_INIT, $urandom);
    sink_hold_cycles = 400;
    repeat (8) issue_command(CMD_ALLOC, $urandom);
    repeat (4)
      issue_command(CMD_FREE, ($urandom_range(0, 7) << PAGE_SHIFT) | $urandom_range(0, 4095));
  endtask

  // Phases of random traffic, each under its own register setting
  task automatic test_random_traffic();
    int          phase;
    int          n;
    int unsigned draw;
    int unsigned pages;
    int unsigned idx;
    logic [31:0] mem_bytes;
    logic [31:0] reserved;
    for (phase = 0; phase < 10; phase++) begin
      draw = $urandom_range(0, 9);
      if (draw < 6) begin
        pages     = $urandom_range(1, 96);
        mem_bytes = (pages << PAGE_SHIFT) | $urandom_range(0, 4095);
        reserved  = $urandom_range(0, pages);
      end else if (draw < 8) begin
        mem_bytes = $urandom;
        reserved  = $urandom_range(0, 8192);
      end else if (draw == 8) begin
        mem_bytes = 32'hFFFF_FFFF;
        reserved  = $urandom_range(8000, 8192);
      end else begin
        mem_bytes = $urandom_range(0, 4095);
        reserved  = $urandom_range(0, 3);
      end
      write_register(CFG_MEM_BYTES, mem_bytes);
      write_register(CFG_RESERVED, reserved);
      quiet_mode = ($urandom_range(0, 3) == 0);
      issue_command(CMD_INIT, $urandom);
      for (n = 0; n < 100; n++) begin
        draw = $urandom_range(0, 99);
        if (draw < 45) begin
          issue_command(CMD_ALLOC, $urandom);
        end else if (draw < 80) begin
          if (pick_used_page(idx))
            issue_command(CMD_FREE, (idx << PAGE_SHIFT) | $urandom_range(0, 4095));
          else
            issue_command(CMD_ALLOC, $urandom);
        end else if (draw < 88) begin
          issue_command(CMD_FREE, $urandom);
        end else if (draw < 93) begin
          issue_command(CMD_FREE,
                        ($urandom_range(0, pool_pages) << PAGE_SHIFT) | $urandom_range(0, 4095));
        end else if (draw < 97) begin
          issue_command(CMD_UNKNOWN, $urandom);
        end else begin
          issue_command(CMD_INIT, $urandom);
        end
      end
    end
    quiet_mode = 1'b0;
  endtask

  // Result side: random stalls per transaction, plus long hold-offs on request
  initial begin : result_sink
    int gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (sink_hold_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (sink_hold_cycles) @(posedge clk);
        sink_hold_cycles = 0;
      end else begin
        gap = quiet_mode ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready) && sink_hold_cycles == 0);
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    page_reply_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (page_replies_due.size() == 0) begin
        flag_fault("unexpected result, alloc_address", 32'h0, out_tdata[31:0]);
      end else begin
        want = page_replies_due.pop_front();
        if (out_tdata[31:0] !== want.alloc_addr)
          flag_fault("alloc_address", want.alloc_addr, out_tdata[31:0]);
        if (out_tuser !== want.status)
          flag_fault("status", 32'(want.status), 32'(out_tuser));
        if (out_tdata[45:32] !== want.free_pages)
          flag_fault("free_pages", 32'(want.free_pages), 32'(out_tdata[45:32]));
      end
    end
  end

  // Hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("bitmap_page_allocator_unit regression: fail");
    $finish;
  end

  initial begin
    in_tvalid        = 1'b0;
    in_tdata         = '0;
    in_tuser         = '0;
    cfg_valid        = 1'b0;
    cfg_index        = 1'b0;
    cfg_data         = '0;
    rst_n            = 1'b0;
    fault_count      = 0;
    sink_hold_cycles = 0;
    quiet_mode       = 1'b0;
    page_used        = '0;
    pool_pages       = 0;
    free_count       = 0;
    shadow_mem_bytes = 32'd33554432;
    shadow_reserved  = 14'd1024;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_before_init();
    test_small_pool();
    test_first_page();
    test_pool_extremes();
    test_output_backpressure();
    test_random_traffic();

    // Drain outstanding results, then watch for strays
    in_tvalid <= 1'b0;
    while (page_replies_due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fault_count == 0 && page_replies_due.size() == 0)
      $display("bitmap_page_allocator_unit regression: pass");
    else
      $display("bitmap_page_allocator_unit regression: fail");
    $finish;
  end

endmodule

>>> sim.f
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/bpa_word_scan.sv
rtl/bitmap_page_allocator_unit.sv
tb/tb_bitmap_page_allocator_unit.sv
